@@ rtl/sbfd_pkg.sv @@
package sbfd_pkg;

  localparam int unsigned CHANNEL_COUNT = 16;
  localparam int unsigned CHAN_W        = 11;
  localparam int unsigned IDX_W         = $clog2(CHANNEL_COUNT);
  localparam int unsigned MEM_AW        = IDX_W + 1;
  localparam int unsigned ACC_W         = 18;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned HELD_W        = 5;

  localparam logic [7:0]        START_BYTE    = 8'h0F;
  localparam logic [7:0]        STOP_BYTE     = 8'h00;
  localparam logic [POS_W-1:0]  FRAME_BYTES   = 5'd25;
  localparam logic [POS_W-1:0]  LAST_DATA_POS = 5'd22;
  localparam logic [POS_W-1:0]  FLAG_POS      = 5'd23;
  localparam logic [POS_W-1:0]  CHECK_POS     = 5'd24;
  localparam logic [HELD_W-1:0] BYTE_BITS     = 5'd8;
  localparam logic [HELD_W-1:0] CHAN_BITS     = 5'd11;
  localparam int unsigned       FAIL_SAFE_BIT = 3;
  localparam int unsigned       LOST_BIT      = 2;
  localparam logic [IDX_W-1:0]  LAST_INDEX    = IDX_W'(CHANNEL_COUNT - 1);

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [CHAN_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic req;
    logic bank;
    logic ok;
    logic fail_safe;
    logic lost_frame;
  } emit_t;

endpackage

@@ rtl/sbfd_unpack.sv @@
module sbfd_unpack (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   frame_first_i,
  output logic                   at_check_o,
  output sbfd_pkg::wr_t          wr_o,
  output sbfd_pkg::emit_t        emit_o
);

  logic [sbfd_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [sbfd_pkg::ACC_W-1:0]  acc_q, acc_d, acc_new;
  logic [sbfd_pkg::HELD_W-1:0] held_q, held_d, held_new;
  logic [sbfd_pkg::IDX_W-1:0]  next_q, next_d;
  logic                        start_ok_q, start_ok_d;
  logic                        fs_q, fs_d;
  logic                        lost_q, lost_d;
  logic                        wbank_q, wbank_d;

  assign at_check_o = (pos_q == sbfd_pkg::CHECK_POS) && !frame_first_i;
  assign acc_new    = acc_q | (sbfd_pkg::ACC_W'(data_byte_i) << held_q[3:0]);
  assign held_new   = held_q + sbfd_pkg::BYTE_BITS;

  always_comb begin
    pos_d      = pos_q;
    acc_d      = acc_q;
    held_d     = held_q;
    next_d     = next_q;
    start_ok_d = start_ok_q;
    fs_d       = fs_q;
    lost_d     = lost_q;
    wbank_d    = wbank_q;
    wr_o       = '0;
    emit_o     = '0;
    if (accept_i) begin
      if (frame_first_i) begin
        acc_d      = '0;
        held_d     = '0;
        next_d     = '0;
        fs_d       = 1'b0;
        lost_d     = 1'b0;
        start_ok_d = (data_byte_i == sbfd_pkg::START_BYTE);
        pos_d      = sbfd_pkg::POS_W'(1);
      end else if (pos_q < sbfd_pkg::FRAME_BYTES) begin
        if (pos_q <= sbfd_pkg::LAST_DATA_POS) begin
          if (held_new >= sbfd_pkg::CHAN_BITS) begin
            wr_o.en   = 1'b1;
            wr_o.addr = {wbank_q, next_q};
            wr_o.data = acc_new[sbfd_pkg::CHAN_W-1:0];
            acc_d     = acc_new >> sbfd_pkg::CHAN_W;
            held_d    = held_new - sbfd_pkg::CHAN_BITS;
            next_d    = next_q + sbfd_pkg::IDX_W'(1);
          end else begin
            acc_d  = acc_new;
            held_d = held_new;
          end
        end else if (pos_q == sbfd_pkg::FLAG_POS) begin
          fs_d   = data_byte_i[sbfd_pkg::FAIL_SAFE_BIT];
          lost_d = data_byte_i[sbfd_pkg::LOST_BIT];
        end else begin
          emit_o.req        = 1'b1;
          emit_o.bank       = wbank_q;
          emit_o.ok         = start_ok_q && (data_byte_i == sbfd_pkg::STOP_BYTE);
          emit_o.fail_safe  = fs_q;
          emit_o.lost_frame = lost_q;
          wbank_d           = ~wbank_q;
        end
        pos_d = pos_q + sbfd_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= sbfd_pkg::FRAME_BYTES;
      acc_q      <= '0;
      held_q     <= '0;
      next_q     <= '0;
      start_ok_q <= 1'b0;
      fs_q       <= 1'b0;
      lost_q     <= 1'b0;
      wbank_q    <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      acc_q      <= acc_d;
      held_q     <= held_d;
      next_q     <= next_d;
      start_ok_q <= start_ok_d;
      fs_q       <= fs_d;
      lost_q     <= lost_d;
      wbank_q    <= wbank_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= sbfd_pkg::FRAME_BYTES)
    else $error("Byte position ran past the idle value.");

  a_emit_toggles_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.req |=> wbank_q != $past(wbank_q))
    else $error("Write bank did not swap at the end of a frame.");

endmodule

@@ rtl/sbfd_drain.sv @@
module sbfd_drain (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sbfd_pkg::wr_t                     wr_i,
  input  sbfd_pkg::emit_t                   emit_i,
  output logic                              busy_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sbfd_pkg::IDX_W-1:0]        channel_index_o,
  output logic [sbfd_pkg::CHAN_W-1:0]       channel_value_o,
  output logic                              fail_safe_o,
  output logic                              lost_frame_o,
  output logic                              frame_error_o,
  output logic                              last_o
);

  localparam int unsigned MEM_DEPTH = 2 * sbfd_pkg::CHANNEL_COUNT;

  logic [sbfd_pkg::CHAN_W-1:0] mem [MEM_DEPTH];
  logic [sbfd_pkg::CHAN_W-1:0] rdata_q;

  logic                       busy_q, busy_d;
  logic                       bank_q, bank_d;
  logic [sbfd_pkg::IDX_W-1:0] cnt_q, cnt_d;
  logic                       err_q, err_d;
  logic                       fs_q, fs_d;
  logic                       lost_q, lost_d;

  logic                       s1_v_q, s1_v_d;
  logic [sbfd_pkg::IDX_W-1:0] s1_idx_q, s1_idx_d;
  logic                       s1_last_q, s1_last_d;
  logic                       s1_err_q, s1_err_d;
  logic                       s1_fs_q, s1_fs_d;
  logic                       s1_lost_q, s1_lost_d;

  logic                        out_v_q, out_v_d;
  logic [sbfd_pkg::IDX_W-1:0]  out_idx_q;
  logic [sbfd_pkg::CHAN_W-1:0] out_val_q;
  logic                        out_fs_q, out_lost_q, out_err_q, out_last_q;

  logic out_adv, s1_move, issue, issue_last;

  assign out_adv    = !out_v_q || !out_stall_i;
  assign s1_move    = s1_v_q && out_adv;
  assign issue      = busy_q && (!s1_v_q || out_adv);
  assign issue_last = err_q || (cnt_q == sbfd_pkg::LAST_INDEX);

  always_comb begin
    busy_d    = busy_q;
    bank_d    = bank_q;
    cnt_d     = cnt_q;
    err_d     = err_q;
    fs_d      = fs_q;
    lost_d    = lost_q;
    s1_v_d    = s1_v_q && !s1_move;
    s1_idx_d  = s1_idx_q;
    s1_last_d = s1_last_q;
    s1_err_d  = s1_err_q;
    s1_fs_d   = s1_fs_q;
    s1_lost_d = s1_lost_q;
    out_v_d   = out_v_q && !out_adv;
    if (s1_move) begin
      out_v_d = 1'b1;
    end
    if (emit_i.req) begin
      busy_d = 1'b1;
      bank_d = emit_i.bank;
      cnt_d  = '0;
      err_d  = !emit_i.ok;
      fs_d   = emit_i.fail_safe;
      lost_d = emit_i.lost_frame;
    end else if (issue) begin
      s1_v_d    = 1'b1;
      s1_idx_d  = err_q ? '0 : cnt_q;
      s1_last_d = issue_last;
      s1_err_d  = err_q;
      s1_fs_d   = fs_q && !err_q;
      s1_lost_d = lost_q && !err_q;
      cnt_d     = cnt_q + sbfd_pkg::IDX_W'(1);
      if (issue_last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (issue && !emit_i.req) begin
      rdata_q <= mem[{bank_q, cnt_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= s1_idx_d;
    s1_last_q <= s1_last_d;
    s1_err_q  <= s1_err_d;
    s1_fs_q   <= s1_fs_d;
    s1_lost_q <= s1_lost_d;
    bank_q    <= bank_d;
    cnt_q     <= cnt_d;
    err_q     <= err_d;
    fs_q      <= fs_d;
    lost_q    <= lost_d;
    if (s1_move) begin
      out_idx_q  <= s1_idx_q;
      out_val_q  <= s1_err_q ? '0 : rdata_q;
      out_fs_q   <= s1_fs_q;
      out_lost_q <= s1_lost_q;
      out_err_q  <= s1_err_q;
      out_last_q <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  assign busy_o          = busy_q;
  assign out_valid_o     = out_v_q;
  assign channel_index_o = out_idx_q;
  assign channel_value_o = out_val_q;
  assign fail_safe_o     = out_fs_q;
  assign lost_frame_o    = out_lost_q;
  assign frame_error_o   = out_err_q;
  assign last_o          = out_last_q;

  a_emit_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_i.req |-> !busy_q)
    else $error("A frame ended while the previous one was still being read.");

  a_no_write_to_read_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && wr_i.en) |-> wr_i.addr[sbfd_pkg::MEM_AW-1] != bank_q)
    else $error("Channel write hit the bank that is being read out.");

  a_error_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_err_q) |-> (out_last_q && out_idx_q == '0 && out_val_q == '0))
    else $error("Error result is not a single cleared result.");

  a_issue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && !emit_i.req && !issue_last) |=> busy_q)
    else $error("Readout stopped before the last channel.");

endmodule

@@ rtl/servo_bus_frame_decoder.sv @@
// After the stop byte is taken, results are read from the RAM into a read stage and then into the
// output register, at one result per cycle while the output is not stalled.
// Throughput: one byte per cycle; the stop byte stalls only while the previous frame is
// still being read from the two-bank channel RAM; with the output unstalled, back-to-back frames run at full rate.
// Reset is asynchronous and active low; the decoder then waits for a frame start, and the
// channel RAM needs no clearing since every frame writes all channels before it is read.
module servo_bus_frame_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        frame_first_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sbfd_pkg::IDX_W-1:0]  channel_index_o,
  output logic [sbfd_pkg::CHAN_W-1:0] channel_value_o,
  output logic                        fail_safe_o,
  output logic                        lost_frame_o,
  output logic                        frame_error_o,
  output logic                        last_o
);

  sbfd_pkg::wr_t   wr;
  sbfd_pkg::emit_t emit;
  logic            at_check;
  logic            busy;
  logic            accept;

  assign in_stall_o = at_check && busy;
  assign accept     = in_valid_i && !in_stall_o;

  sbfd_unpack u_unpack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .frame_first_i (frame_first_i),
    .at_check_o    (at_check),
    .wr_o          (wr),
    .emit_o        (emit)
  );

  sbfd_drain u_drain (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_i            (wr),
    .emit_i          (emit),
    .busy_o          (busy),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .fail_safe_o     (fail_safe_o),
    .lost_frame_o    (lost_frame_o),
    .frame_error_o   (frame_error_o),
    .last_o          (last_o)
  );

endmodule

@@ dv/frame_decode_checker.sv @@
`timescale 1ns / 100ps

module frame_decode_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [7:0]                  data_byte_i,
  input  logic                        frame_first_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [sbfd_pkg::IDX_W-1:0]  channel_index_i,
  input  logic [sbfd_pkg::CHAN_W-1:0] channel_value_i,
  input  logic                        fail_safe_i,
  input  logic                        lost_frame_i,
  input  logic                        frame_error_i,
  input  logic                        last_i,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 results_pending_o
);

  typedef struct packed {
    logic [sbfd_pkg::IDX_W-1:0]  index;
    logic [sbfd_pkg::CHAN_W-1:0] value;
    logic                        fail_safe;
    logic                        lost_frame;
    logic                        frame_error;
    logic                        last;
  } chan_result_t;

  logic [sbfd_pkg::POS_W-1:0]  frame_pos;
  logic [sbfd_pkg::ACC_W-1:0]  bit_acc;
  logic [sbfd_pkg::HELD_W-1:0] bits_held;
  logic [sbfd_pkg::IDX_W-1:0]  chan_ptr;
  logic [sbfd_pkg::CHAN_W-1:0] chan_mem [sbfd_pkg::CHANNEL_COUNT];
  logic                        start_ok;
  logic                        fs_flag;
  logic                        lost_flag;

  chan_result_t channel_results_due [$];
  int unsigned  mismatch_count = 0;

  assign mismatch_count_o = mismatch_count;

  task automatic clear_decoder();
    int k;
    frame_pos = sbfd_pkg::FRAME_BYTES;
    bit_acc   = '0;
    bits_held = '0;
    chan_ptr  = '0;
    start_ok  = 1'b0;
    fs_flag   = 1'b0;
    lost_flag = 1'b0;
    for (k = 0; k < sbfd_pkg::CHANNEL_COUNT; k++) begin
      chan_mem[k] = '0;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic first);
    chan_result_t r;
    int k;
    if (first) begin
      bit_acc   = '0;
      bits_held = '0;
      chan_ptr  = '0;
      fs_flag   = 1'b0;
      lost_flag = 1'b0;
      start_ok  = (b == sbfd_pkg::START_BYTE);
      frame_pos = sbfd_pkg::POS_W'(1);
    end else if (frame_pos < sbfd_pkg::FRAME_BYTES) begin
      if (frame_pos <= sbfd_pkg::LAST_DATA_POS) begin
        bit_acc   = bit_acc | (sbfd_pkg::ACC_W'(b) << bits_held);
        bits_held = bits_held + sbfd_pkg::BYTE_BITS;
        if (bits_held >= sbfd_pkg::CHAN_BITS) begin
          chan_mem[chan_ptr] = bit_acc[sbfd_pkg::CHAN_W-1:0];
          bit_acc   = bit_acc >> sbfd_pkg::CHAN_BITS;
          bits_held = bits_held - sbfd_pkg::CHAN_BITS;
          chan_ptr  = chan_ptr + sbfd_pkg::IDX_W'(1);
        end
      end else if (frame_pos == sbfd_pkg::FLAG_POS) begin
        fs_flag   = b[sbfd_pkg::FAIL_SAFE_BIT];
        lost_flag = b[sbfd_pkg::LOST_BIT];
      end else if (start_ok && b == sbfd_pkg::STOP_BYTE) begin
        for (k = 0; k < sbfd_pkg::CHANNEL_COUNT; k++) begin
          r.index       = sbfd_pkg::IDX_W'(k);
          r.value       = chan_mem[k];
          r.fail_safe   = fs_flag;
          r.lost_frame  = lost_flag;
          r.frame_error = 1'b0;
          r.last        = (sbfd_pkg::IDX_W'(k) == sbfd_pkg::LAST_INDEX);
          channel_results_due.push_back(r);
        end
      end else begin
        r             = '0;
        r.frame_error = 1'b1;
        r.last        = 1'b1;
        channel_results_due.push_back(r);
      end
      frame_pos = frame_pos + sbfd_pkg::POS_W'(1);
    end
  endtask

  task automatic note_mismatch(input logic have_want, input chan_result_t want,
                               input chan_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (have_want) begin
        $display("%0t: expected idx=%0d val=%0d fs=%b lost=%b err=%b last=%b", $realtime,
                 want.index, want.value, want.fail_safe, want.lost_frame,
                 want.frame_error, want.last);
      end else begin
        $display("%0t: expected no channel result", $realtime);
      end
      $display("%0t: actual   idx=%0d val=%0d fs=%b lost=%b err=%b last=%b", $realtime,
               got.index, got.value, got.fail_safe, got.lost_frame,
               got.frame_error, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    chan_result_t got;
    chan_result_t want;
    if (!rst_ni) begin
      clear_decoder();
      channel_results_due.delete();
      results_pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        decode_byte(data_byte_i, frame_first_i);
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{channel_index_i, channel_value_i, fail_safe_i, lost_frame_i,
                frame_error_i, last_i};
        if (channel_results_due.size() == 0) begin
          note_mismatch(1'b0, '0, got);
        end else begin
          want = channel_results_due.pop_front();
          if (got.index !== want.index || got.value !== want.value ||
              got.fail_safe !== want.fail_safe || got.lost_frame !== want.lost_frame ||
              got.frame_error !== want.frame_error || got.last !== want.last) begin
            note_mismatch(1'b1, want, got);
          end
        end
      end
      results_pending_o <= channel_results_due.size();
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  typedef enum logic [1:0] {
    FRAME_GOOD,
    FRAME_BAD_START,
    FRAME_BAD_STOP,
    FRAME_CUT
  } frame_kind_e;

  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES,
    FILL_ALTERNATE
  } fill_e;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_stall_o;
  logic [7:0]                  data_byte_i   = '0;
  logic                        frame_first_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i   = 1'b0;
  logic [sbfd_pkg::IDX_W-1:0]  channel_index_o;
  logic [sbfd_pkg::CHAN_W-1:0] channel_value_o;
  logic                        fail_safe_o;
  logic                        lost_frame_o;
  logic                        frame_error_o;
  logic                        last_o;

  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned items_sent = 0;
  logic        send_quiet = 1'b0;
  logic        recv_quiet = 1'b0;

  servo_bus_frame_decoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .frame_first_i   (frame_first_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .fail_safe_o     (fail_safe_o),
    .lost_frame_o    (lost_frame_o),
    .frame_error_o   (frame_error_o),
    .last_o          (last_o)
  );

  frame_decode_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .frame_first_i     (frame_first_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .channel_index_i   (channel_index_o),
    .channel_value_i   (channel_value_o),
    .fail_safe_i       (fail_safe_o),
    .lost_frame_i      (lost_frame_o),
    .frame_error_i     (frame_error_o),
    .last_i            (last_o),
    .mismatch_count_o  (mismatch_count),
    .results_pending_o (results_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic first);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    frame_first_i <= first;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_frame(input frame_kind_e kind, input fill_e fill,
                            input logic [7:0] flags);
    logic [7:0]  b;
    int unsigned span;
    int unsigned i;
    if (kind == FRAME_BAD_START) begin
      do b = 8'($urandom_range(0, 255)); while (b == sbfd_pkg::START_BYTE);
    end else begin
      b = sbfd_pkg::START_BYTE;
    end
    send_byte(b, 1'b1);
    items_sent++;
    span = (kind == FRAME_CUT) ? $urandom_range(0, 23) : 24;
    for (i = 1; i <= span; i++) begin
      if (i <= sbfd_pkg::LAST_DATA_POS) begin
        case (fill)
          FILL_ZERO:      b = 8'h00;
          FILL_ONES:      b = 8'hFF;
          FILL_ALTERNATE: b = i[0] ? 8'hAA : 8'h55;
          default:        b = 8'($urandom_range(0, 255));
        endcase
      end else if (i == sbfd_pkg::FLAG_POS) begin
        b = flags;
      end else if (kind == FRAME_BAD_STOP) begin
        b = 8'($urandom_range(1, 255));
      end else begin
        b = sbfd_pkg::STOP_BYTE;
      end
      send_byte(b, 1'b0);
      items_sent++;
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned n;
    wait (rst_ni);
    forever begin
      n = recv_quiet ? 0 : $urandom_range(0, 14);
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      if ($urandom_range(0, 39) == 0) begin
        recv_quiet = !recv_quiet;
      end
    end
  end

  initial begin
    int unsigned frame_no;
    int unsigned pick;
    frame_kind_e kind;
    fill_e       fill;
    frame_no = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bytes before any frame start must be dropped silently.
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_frame(FRAME_GOOD, FILL_ONES, 8'hFF);
    send_byte(8'($urandom_range(0, 255)), 1'b0);

    while (items_sent < 360) begin
      send_quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        kind = FRAME_GOOD;
      end else if (pick < 72) begin
        kind = FRAME_BAD_START;
      end else if (pick < 84) begin
        kind = FRAME_BAD_STOP;
      end else begin
        kind = FRAME_CUT;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        fill = FILL_ZERO;
      end else if (pick == 1) begin
        fill = FILL_ONES;
      end else if (pick == 2) begin
        fill = FILL_ALTERNATE;
      end else begin
        fill = FILL_RANDOM;
      end
      send_frame(kind, fill, 8'($urandom_range(0, 255)));
      if (kind != FRAME_CUT) begin
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      frame_no++;
      if (frame_no % 6 == 3) begin
        wait_for_results();
      end
    end

    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ servo_bus_frame_decoder.f @@
rtl/sbfd_pkg.sv
rtl/sbfd_unpack.sv
rtl/sbfd_drain.sv
rtl/servo_bus_frame_decoder.sv
dv/frame_decode_checker.sv
dv/testbench.sv
